// ----- rtl/assert_macros.svh -----
// assert_macros.svh: assertion macros shared by the grant sizer RTL
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every clock edge outside reset
`define PGS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition implies a consequence in the same cycle
`define PGS_ASSERT_IMP(label, cond, cons, msg) \
	`PGS_ASSERT(label, (cond) |-> (cons), msg)

`endif

// ----- rtl/pgs_pkg.sv -----
`timescale 1ns / 1ps
// pgs_pkg: word types, register codes and reset values of the grant sizer.
// Depends on nothing; imported by every grant sizer module but pgs_ram.
package pgs_pkg;

	localparam int BYTES_W   = 24;
	localparam int IDX_W     = 5;
	localparam int NQ_W      = 7;
	localparam int CFG_IDX_W = 4;

	typedef logic [BYTES_W-1:0]   bytes_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_MAX_WINDOW      = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_HEAVY_THRESHOLD = cfg_idx_t'(1);
	localparam cfg_idx_t CFG_BOOST_ENABLE    = cfg_idx_t'(2);
	localparam cfg_idx_t CFG_BOOST_BYTES     = cfg_idx_t'(3);

	localparam bytes_t MAX_WINDOW_RST      = bytes_t'(15000);
	localparam bytes_t HEAVY_THRESHOLD_RST = bytes_t'(15000);
	localparam bytes_t BOOST_BYTES_RST     = bytes_t'(8000);

	typedef struct packed {
		logic [IDX_W-1:0] onu_index;
		bytes_t           request_bytes;
		bytes_t           down_buffered_bytes;
		bytes_t           down_granted_bytes;
		logic             onu_asleep;
	} report_t;

	typedef struct packed {
		bytes_t          up_grant;
		bytes_t          down_grant;
		bytes_t          larger_grant;
		logic            heavy;
		logic            down_larger;
		logic [NQ_W-1:0] next_quota;
	} grant_t;

	typedef struct packed {
		bytes_t max_window;
		bytes_t heavy_threshold;
		logic   boost_enable;
		bytes_t boost_bytes;
	} cfg_t;

	typedef struct packed {
		bytes_t up;
		bytes_t down;
		bytes_t larger;
		logic   heavy;
		logic   down_larger;
		bytes_t rest;
	} sized_t;

	typedef struct packed {
		logic             valid;
		logic             in_range;
		logic [IDX_W-1:0] idx;
	} tag_t;

endpackage

// ----- rtl/pon_onu_grant_sizer.sv -----
// Throughput: one report per cycle while grant_ready keeps the output stage moving; a
// report for a terminal whose earlier report is still in the pipeline waits until that
// report has written its quota back to the quota RAM (read in stage 1, written on entry
// to the output stage).
// Reset sets the config registers to their defaults and clears the quota valid bits and
// the pipeline valid bits; quota entries not yet written read as zero, with no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pon_onu_grant_sizer
	import pgs_pkg::*;
#(
	parameter int TERMINALS   = 32,
	parameter int QUOTA_STEPS = 100
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     report_valid,
	output logic     report_ready,
	input  report_t  report,
	output logic     grant_valid,
	input  logic     grant_ready,
	output grant_t   grant,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  cfg_idx_t cfg_index,
	input  bytes_t   cfg_data
);

	localparam int QW  = $clog2(QUOTA_STEPS + 1);
	localparam int AW  = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
	localparam int LAT = 8 + QW;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_window      <= MAX_WINDOW_RST;
			cfg_q.heavy_threshold <= HEAVY_THRESHOLD_RST;
			cfg_q.boost_enable    <= 1'b0;
			cfg_q.boost_bytes     <= BOOST_BYTES_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAX_WINDOW:      cfg_q.max_window      <= cfg_data;
				CFG_HEAVY_THRESHOLD: cfg_q.heavy_threshold <= cfg_data;
				CFG_BOOST_ENABLE:    cfg_q.boost_enable    <= cfg_data[0];
				CFG_BOOST_BYTES:     cfg_q.boost_bytes     <= cfg_data;
				default: ;
			endcase
		end
	end

	tag_t tag_q [1:LAT];
	logic en;
	logic hazard;
	logic accept;
	logic in_range;

	always_comb begin
		hazard = 1'b0;
		for (int t = 1; t < LAT; t++) begin
			hazard = hazard || (tag_q[t].valid && tag_q[t].in_range &&
				(tag_q[t].idx == report.onu_index));
		end
	end

	assign en           = !tag_q[LAT].valid || grant_ready;
	assign report_ready = en && !hazard;
	assign accept       = report_valid && report_ready;
	assign in_range     = int'(report.onu_index) < TERMINALS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 1; t <= LAT; t++) begin
				tag_q[t] <= '0;
			end
		end else if (en) begin
			tag_q[1] <= '{valid: accept, in_range: in_range, idx: report.onu_index};
			for (int t = 2; t <= LAT; t++) begin
				tag_q[t] <= tag_q[t-1];
			end
		end
	end

	report_t report_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			report_s1 <= report;
		end
	end

	logic [AW+IDX_W-1:0] rd_addr_w, addr_s1_w, wr_addr_w;
	logic [AW-1:0]       rd_addr, addr_s1, wr_addr;
	logic [QW-1:0]       rd_data, quota_s1, wr_data;
	logic                wr_en;
	logic [TERMINALS-1:0] qvalid_q;

	assign rd_addr_w = (AW+IDX_W)'(report.onu_index);
	assign addr_s1_w = (AW+IDX_W)'(tag_q[1].idx);
	assign wr_addr_w = (AW+IDX_W)'(tag_q[LAT-1].idx);
	assign rd_addr   = rd_addr_w[AW-1:0];
	assign addr_s1   = addr_s1_w[AW-1:0];
	assign wr_addr   = wr_addr_w[AW-1:0];
	assign wr_en     = en && tag_q[LAT-1].valid && tag_q[LAT-1].in_range;
	assign quota_s1  = (tag_q[1].in_range && qvalid_q[addr_s1]) ? rd_data : '0;

	pgs_ram #(
		.WIDTH(QW),
		.DEPTH(TERMINALS)
	) u_quota_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qvalid_q <= '0;
		end else if (wr_en) begin
			qvalid_q[wr_addr] <= 1'b1;
		end
	end

	sized_t sized_s6;
	sized_t sized_last;

	pgs_grant #(
		.QUOTA_STEPS(QUOTA_STEPS)
	) u_grant (
		.clk      (clk),
		.en       (en),
		.report_s1(report_s1),
		.quota_s1 (quota_s1),
		.cfg      (cfg_q),
		.sized_s6 (sized_s6)
	);

	pgs_quota #(
		.QUOTA_STEPS(QUOTA_STEPS)
	) u_quota (
		.clk       (clk),
		.en        (en),
		.sized_s6  (sized_s6),
		.max_window(cfg_q.max_window),
		.sized_out (sized_last),
		.next_quota(wr_data)
	);

	grant_t grant_q;

	always_ff @(posedge clk) begin
		if (en) begin
			grant_q.up_grant     <= sized_last.up;
			grant_q.down_grant   <= sized_last.down;
			grant_q.larger_grant <= sized_last.larger;
			grant_q.heavy        <= sized_last.heavy;
			grant_q.down_larger  <= sized_last.down_larger;
			grant_q.next_quota   <= NQ_W'(wr_data);
		end
	end

	assign grant       = grant_q;
	assign grant_valid = tag_q[LAT].valid;

	`PGS_ASSERT_IMP(a_quota_bound, wr_en, wr_data <= QW'(QUOTA_STEPS), "quota above full window")
	`PGS_ASSERT_IMP(a_up_bound, grant_valid, grant.up_grant <= cfg_q.max_window, "upstream grant above window")
	`PGS_ASSERT_IMP(a_light_quota, grant_valid && !grant.heavy, grant.next_quota == '0, "light word with quota")

endmodule

// ----- rtl/pgs_ram.sv -----
`timescale 1ns / 1ps
// pgs_ram: generic single write port RAM with a registered read port.
// Depends on nothing.
module pgs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/pgs_grant.sv -----
`timescale 1ns / 1ps
// pgs_grant: stages 2 to 6, upstream and downstream grant sizing and heavy class.
// Depends on pgs_pkg.
module pgs_grant
	import pgs_pkg::*;
#(
	parameter int QUOTA_STEPS = 100,
	localparam int QW = $clog2(QUOTA_STEPS + 1)
) (
	input  logic          clk,
	input  logic          en,
	input  report_t       report_s1,
	input  logic [QW-1:0] quota_s1,
	input  cfg_t          cfg,
	output sized_t        sized_s6
);

	localparam int PW = BYTES_W + QW;
	localparam int K  = PW;
	localparam int MW = K - $clog2(QUOTA_STEPS) + 1;
	localparam int HW = (PW + 1) / 2;
	localparam int LW = PW - HW;
	localparam logic [MW-1:0] RECIP   = MW'((64'd1 << K) / QUOTA_STEPS);
	localparam logic [PW-1:0] STEPS_P = PW'(QUOTA_STEPS);

	// stage 1 to 2: quota times window, zero quota grant
	logic [BYTES_W:0] boost_sum;
	bytes_t           small_up;
	logic [PW-1:0]    prod;

	always_comb begin
		boost_sum = {1'b0, report_s1.request_bytes} + {1'b0, cfg.boost_bytes};
		if (report_s1.request_bytes >= cfg.max_window) begin
			small_up = cfg.max_window;
		end else if (cfg.boost_enable) begin
			small_up = (boost_sum < {1'b0, cfg.max_window}) ?
				boost_sum[BYTES_W-1:0] : cfg.max_window;
		end else begin
			small_up = report_s1.request_bytes;
		end
		prod = PW'(quota_s1) * PW'(cfg.max_window);
	end

	report_t       report_s2, report_s3, report_s4, report_s5;
	logic [PW-1:0] prod_s2, prod_s3, prod_s4;
	bytes_t        small_s2, small_s3, small_s4, small_s5;
	logic          sat_s2, sat_s3, sat_s4, sat_s5;
	logic          frac_s2, frac_s3, frac_s4, frac_s5;
	logic [HW+MW-1:0] pp_lo_s3;
	logic [LW+MW-1:0] pp_hi_s3;
	bytes_t        est_s4;
	bytes_t        frac_up_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			report_s2 <= report_s1;
			prod_s2   <= prod;
			small_s2  <= small_up;
			sat_s2    <= quota_s1 >= QW'(QUOTA_STEPS);
			frac_s2   <= quota_s1 != '0;
		end
	end

	// stage 2 to 3: reciprocal product in two halves
	always_ff @(posedge clk) begin
		if (en) begin
			report_s3 <= report_s2;
			prod_s3   <= prod_s2;
			small_s3  <= small_s2;
			sat_s3    <= sat_s2;
			frac_s3   <= frac_s2;
			pp_lo_s3  <= (HW+MW)'(prod_s2[HW-1:0]) * (HW+MW)'(RECIP);
			pp_hi_s3  <= (LW+MW)'(prod_s2[PW-1:HW]) * (LW+MW)'(RECIP);
		end
	end

	// stage 3 to 4: join halves, keep the quotient estimate
	logic [PW+MW-1:0] recip_full;

	always_comb begin
		recip_full = ((PW+MW)'(pp_hi_s3) << HW) + (PW+MW)'(pp_lo_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			report_s4 <= report_s3;
			prod_s4   <= prod_s3;
			small_s4  <= small_s3;
			sat_s4    <= sat_s3;
			frac_s4   <= frac_s3;
			est_s4    <= recip_full[K +: BYTES_W];
		end
	end

	// stage 4 to 5: estimate may be one short, correct it
	logic [PW-1:0] est_rem;

	always_comb begin
		est_rem = prod_s4 - PW'(est_s4) * STEPS_P;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			report_s5  <= report_s4;
			small_s5   <= small_s4;
			sat_s5     <= sat_s4;
			frac_s5    <= frac_s4;
			frac_up_s5 <= est_s4 + BYTES_W'(est_rem >= STEPS_P);
		end
	end

	// stage 5 to 6: final grants, leftover and class
	sized_t sized;
	bytes_t backlog;
	bytes_t rel;

	always_comb begin
		if (sat_s5) begin
			sized.up = cfg.max_window;
		end else if (frac_s5) begin
			sized.up = frac_up_s5;
		end else begin
			sized.up = small_s5;
		end
		sized.down = report_s5.onu_asleep ? '0 : report_s5.down_granted_bytes;
		sized.larger = (sized.up > sized.down) ? sized.up : sized.down;
		sized.down_larger = report_s5.down_buffered_bytes > report_s5.request_bytes;
		if (sized.down_larger) begin
			rel = sized.down;
			backlog = report_s5.down_buffered_bytes;
			sized.rest = (report_s5.down_buffered_bytes > sized.down) ?
				report_s5.down_buffered_bytes - sized.down : '0;
		end else begin
			rel = sized.up;
			backlog = report_s5.request_bytes;
			sized.rest = (report_s5.request_bytes > sized.up) ?
				report_s5.request_bytes - sized.up : '0;
		end
		sized.heavy = (backlog >= cfg.heavy_threshold) && (rel != '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sized_s6 <= sized;
		end
	end

endmodule

// ----- rtl/pgs_quota.sv -----
`timescale 1ns / 1ps
// pgs_quota: stage 7 and the restoring divider stages for the next quota.
// Depends on pgs_pkg.
module pgs_quota
	import pgs_pkg::*;
#(
	parameter int QUOTA_STEPS = 100,
	localparam int QW = $clog2(QUOTA_STEPS + 1)
) (
	input  logic          clk,
	input  logic          en,
	input  sized_t        sized_s6,
	input  bytes_t        max_window,
	output sized_t        sized_out,
	output logic [QW-1:0] next_quota
);

	localparam int NW = BYTES_W + QW;

	logic [NW-1:0] rem_sd   [0:QW];
	logic [QW-1:0] quo_sd   [0:QW];
	sized_t        sized_sd [0:QW];
	logic          sat_sd   [0:QW];
	logic          zero_sd  [0:QW];

	// stage 6 to 7: scale leftover, flag saturation and the zero result
	always_ff @(posedge clk) begin
		if (en) begin
			rem_sd[0]   <= NW'(sized_s6.rest) * NW'(QUOTA_STEPS);
			quo_sd[0]   <= '0;
			sized_sd[0] <= sized_s6;
			sat_sd[0]   <= (sized_s6.rest >= max_window) && (sized_s6.rest != '0);
			zero_sd[0]  <= !sized_s6.heavy || (sized_s6.rest == '0);
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 0; j < QW; j++) begin : g_step
		localparam int B = QW - 1 - j;
		logic [NW-1:0] dvs;
		logic          take;

		always_comb begin
			dvs  = NW'(max_window) << B;
			take = rem_sd[j] >= dvs;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[j+1]   <= take ? rem_sd[j] - dvs : rem_sd[j];
				quo_sd[j+1]   <= quo_sd[j] | (QW'(take) << B);
				sized_sd[j+1] <= sized_sd[j];
				sat_sd[j+1]   <= sat_sd[j];
				zero_sd[j+1]  <= zero_sd[j];
			end
		end
	end

	always_comb begin
		sized_out = sized_sd[QW];
		if (zero_sd[QW]) begin
			next_quota = '0;
		end else if (sat_sd[QW]) begin
			next_quota = QW'(QUOTA_STEPS);
		end else begin
			next_quota = quo_sd[QW];
		end
	end

endmodule
